// ----- rtl/core/lrf_pkg.sv -----
// ----------------------------------------------------------------------------
// lrf_pkg: shared types and constants of the led ring fade engine
// Level, fade and color constants and the command struct that travels
// from the front end through the command queue to the LED engine.
// ----------------------------------------------------------------------------
`default_nettype none
package lrf_pkg;
	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_ON   = 2'd1;
	localparam logic [1:0] OP_OFF  = 2'd2;

	localparam logic [1:0] VC_SYN1 = 2'd0;

	localparam logic [6:0] DSLOT_KICK  = 7'd0;
	localparam logic [6:0] DSLOT_SNARE = 7'd1;
	localparam logic [6:0] DSLOT_CH    = 7'd6;
	localparam logic [6:0] DSLOT_OH    = 7'd7;

	localparam logic [15:0] LVL_ONE     = 16'd32768;
	localparam logic [15:0] LVL_SEVEN   = 16'd22937;
	localparam logic [15:0] LVL_RESET   = 16'd1638;
	localparam logic [15:0] FADE_NORMAL = 16'd60293;
	localparam logic [15:0] FADE_SLIDE  = 16'd63569;
	localparam logic [15:0] FADE_KICK   = 16'd61603;
	localparam logic [15:0] FADE_CH     = 16'd57671;
	localparam logic [15:0] FADE_OH     = 16'd62259;
	localparam logic [15:0] FADE_PERC   = 16'd60948;

	localparam logic [23:0] HUE_SYN1  = 24'h00C8DC;
	localparam logic [23:0] HUE_SYN2  = 24'hDC00C8;
	localparam logic [23:0] HUE_KICK  = 24'hFFFFFF;
	localparam logic [23:0] HUE_SNARE = 24'hFFDC00;
	localparam logic [23:0] HUE_CH    = 24'h00FF3C;
	localparam logic [23:0] HUE_OH    = 24'h00DC28;
	localparam logic [23:0] HUE_PERC  = 24'hFF7800;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_SYNTH = 2'd1;
	localparam logic [1:0] CMD_DRUM  = 2'd2;
	localparam logic [1:0] CMD_OFF   = 2'd3;

	// classified command from the front end
	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  led;
		logic [3:0]  arc_first;
		logic [3:0]  arc_last;
		logic [23:0] hue;
		logic [15:0] fade;
		logic        accent;
		logic        slide;
	} cmd_t;
endpackage
`default_nettype wire

// ----- rtl/core/led_ring_fade_visualizer_top.sv -----
// ----------------------------------------------------------------------------
// led_ring_fade_visualizer_top: sixteen-LED fade engine
// channel   | ports                                    | handshake
// event     | opcode voice note accent slide           | start & !busy
// result    | led_index red green blue last            | strobe
// config    | floor_level_wdata                        | floor_level_we
// A tick is decoded, queued and then holds the engine while each LED
// passes the tick state (ramp or fade), then the mult state (floor). Result
// beats never come back to back. A synth note on with accent walks the arc,
// one LED per cycle; other commands are applied as they are taken. busy is
// high while the two-entry queue is full, or holds one command with a
// decoded beat about to enter. Reset restores all LED state at once; the
// receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none
module led_ring_fade_visualizer_top import lrf_pkg::*; #(
	parameter int DRUM_SLOTS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  opcode,
	input  wire logic [1:0]  voice,
	input  wire logic [6:0]  note,
	input  wire logic        accent,
	input  wire logic        slide,
	input  wire logic        floor_level_we,
	input  wire logic [15:0] floor_level_wdata,
	output logic             strobe,
	output logic [3:0]       led_index,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue,
	output logic             last
);
	logic [15:0] floor_q;
	logic        cmd_valid_s1, q_ne, q_nf, pop;
	cmd_t        cmd_s1, head;

	// leave room for the beat already in the decoder stage
	assign busy = !q_nf || (cmd_valid_s1 && q_ne);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) floor_q <= LVL_RESET;
		else if (floor_level_we) floor_q <= floor_level_wdata;
	end

	lrf_front #(.DRUM_SLOTS(DRUM_SLOTS)) u_front (
		.clk, .arst_n, .take(start && !busy), .opcode, .voice, .note,
		.accent, .slide, .cmd_valid_s1, .cmd_s1
	);

	lrf_queue u_queue (
		.clk, .arst_n, .push(cmd_valid_s1), .push_data(cmd_s1), .pop,
		.not_empty(q_ne), .not_full(q_nf), .head
	);

	lrf_engine u_engine (
		.clk, .arst_n, .floor_level(floor_q), .cmd_valid(q_ne), .cmd(head),
		.cmd_pop(pop), .strobe, .led_index, .red, .green, .blue, .last
	);
endmodule
`default_nettype wire

// ----- rtl/core/lrf_front.sv -----
// ----------------------------------------------------------------------------
// lrf_front: command decoder
// Maps each accepted event to a target LED, color and fade factor.
// ----------------------------------------------------------------------------
`default_nettype none
module lrf_front import lrf_pkg::*; #(
	parameter int DRUM_SLOTS = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       take,
	input  wire logic [1:0] opcode,
	input  wire logic [1:0] voice,
	input  wire logic [6:0] note,
	input  wire logic       accent,
	input  wire logic       slide,
	output logic            cmd_valid_s1,
	output cmd_t            cmd_s1
);
	// note / DRUM_SLOTS as a reciprocal multiply, exact for notes below 128
	localparam int unsigned SLOT_RECIP = (16384 + DRUM_SLOTS - 1) / DRUM_SLOTS;

	logic [6:0]  nclamp, slot, squot;
	logic [20:0] sprod;
	logic [9:0]  prod;
	logic [3:0]  pos, len;
	logic [6:0]  diff;
	logic        is_drum;
	cmd_t        cmd;

	always_comb begin
		nclamp = (note < 7'd24) ? 7'd24 : ((note > 7'd96) ? 7'd96 : note);
		diff   = nclamp - 7'd24;
		len    = (voice == VC_SYN1) ? 4'd6 : 4'd5;
		prod   = 10'(diff) * 10'(len);
		// divide by 60 via small compare ladder: quotient is 0..6
		pos = 4'd0;
		for (int k = 1; k <= 6; k++) begin
			if (prod >= 10'(60 * k)) pos = 4'(k);
		end
		if (pos >= len) pos = len - 4'd1;
		sprod = 21'(note) * 21'(SLOT_RECIP);
		squot = sprod[20:14];
		slot  = note - 7'(32'(squot) * DRUM_SLOTS);
		is_drum = voice[1];

		cmd = '0;
		cmd.accent    = accent;
		cmd.slide     = slide;
		cmd.arc_first = (voice == VC_SYN1) ? 4'd0 : 4'd6;
		cmd.arc_last  = (voice == VC_SYN1) ? 4'd5 : 4'd10;
		cmd.led       = cmd.arc_first + pos;
		cmd.hue       = (voice == VC_SYN1) ? HUE_SYN1 : HUE_SYN2;
		cmd.fade      = slide ? FADE_SLIDE : FADE_NORMAL;
		unique case (opcode)
			OP_TICK: cmd.kind = CMD_TICK;
			OP_ON:   cmd.kind = is_drum ? CMD_DRUM : CMD_SYNTH;
			default: cmd.kind = CMD_OFF;
		endcase
		if (is_drum && opcode == OP_ON) begin
			case (slot)
				DSLOT_KICK: begin
					cmd.led = 4'd11; cmd.hue = HUE_KICK; cmd.fade = FADE_KICK;
				end
				DSLOT_SNARE: begin
					cmd.led = 4'd12; cmd.hue = HUE_SNARE; cmd.fade = FADE_NORMAL;
				end
				DSLOT_CH: begin
					cmd.led = 4'd13; cmd.hue = HUE_CH; cmd.fade = FADE_CH;
				end
				DSLOT_OH: begin
					cmd.led = 4'd14; cmd.hue = HUE_OH; cmd.fade = FADE_OH;
				end
				default: begin
					cmd.led = 4'd15; cmd.hue = HUE_PERC; cmd.fade = FADE_PERC;
				end
			endcase
		end
	end

	// drum note off and opcode three produce nothing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else begin
			cmd_valid_s1 <= take && (opcode == OP_TICK || opcode == OP_ON ||
				(opcode == OP_OFF && !is_drum));
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1 <= cmd;
	end
endmodule
`default_nettype wire

// ----- rtl/core/lrf_queue.sv -----
// ----------------------------------------------------------------------------
// lrf_queue: command queue
// Small fifo between the decoder and the LED engine.
// ----------------------------------------------------------------------------
`default_nettype none
module lrf_queue import lrf_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_data,
	input  wire logic pop,
	output logic      not_empty,
	output logic      not_full,
	output cmd_t      head
);
	cmd_t       mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign not_empty = (cnt_q != 2'd0);
	assign not_full  = (cnt_q != 2'd2);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule
`default_nettype wire

// ----- rtl/core/lrf_engine.sv -----
// ----------------------------------------------------------------------------
// lrf_engine: LED state and tick sequencer
// Applies note commands; on a tick, taking no new command until done, it
// walks the 16 LEDs in turn, updating level and emitting scaled color.
// ----------------------------------------------------------------------------
`default_nettype none
module lrf_engine import lrf_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [15:0] floor_level,
	input  wire logic        cmd_valid,
	input  wire cmd_t        cmd,
	output logic             cmd_pop,
	output logic             strobe,
	output logic [3:0]       led_index,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue,
	output logic             last
);
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_BOOST = 2'd1;
	localparam logic [1:0] ST_TICK  = 2'd2;
	localparam logic [1:0] ST_MULT  = 2'd3;

	logic [15:0] level_q [16];
	logic [15:0] fade_q  [16];
	logic        ramp_q  [16];
	logic [15:0] goal_q  [16];
	logic [15:0] inc_q   [16];
	logic [23:0] hue_q   [16];

	logic [1:0]  state_q;
	logic [3:0]  idx_q, skip_q, last_led_q;
	logic [31:0] prod_s1;
	logic [15:0] lv_s1;
	logic [23:0] hue_s1;
	logic [3:0]  idx_s1;
	logic        out_v_s1;
	logic        idle;

	logic [15:0] cur, goal, gap, nlv, fl, bb;
	logic [16:0] sum;
	logic [19:0] boost;
	logic [15:0] bgoal;
	logic [31:0] gq;
	logic [33:0] bq;

	assign idle    = (state_q == ST_IDLE);
	assign cmd_pop = idle && cmd_valid;

	always_comb begin
		cur  = level_q[cmd.led];
		goal = cmd.accent ? LVL_ONE : LVL_SEVEN;
		gap  = (goal > cur) ? goal - cur : cur - goal;
		// gap / 5 as a reciprocal multiply, exact for 16-bit gaps
		gq = 32'(gap) * 32'd52429;
		// level*13/10 for the boosted neighbor at idx_q, as (x/2)/5
		boost = 20'(level_q[idx_q]) * 20'd13;
		bq = 34'(boost[19:1]) * 34'd52429;
		bgoal = (boost >= 20'd327680) ? LVL_ONE : bq[33:18];
		// ramp step for led idx_q
		sum = 17'(level_q[idx_q]) + 17'(inc_q[idx_q]);
		if (level_q[idx_q] < goal_q[idx_q])
			nlv = (sum > 17'(goal_q[idx_q])) ? goal_q[idx_q] : sum[15:0];
		else if (level_q[idx_q] > goal_q[idx_q])
			nlv = (level_q[idx_q] - goal_q[idx_q] > inc_q[idx_q]) ?
				level_q[idx_q] - inc_q[idx_q] : goal_q[idx_q];
		else
			nlv = level_q[idx_q];
		fl = (prod_s1[31:16] != 16'd0 && prod_s1[31:16] < floor_level) ?
			floor_level : prod_s1[31:16];
		bb = (lv_s1 > LVL_ONE) ? LVL_ONE : lv_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			skip_q <= '0;
			last_led_q <= '0;
			idx_s1 <= '0;
			hue_s1 <= '0;
			prod_s1 <= '0;
			lv_s1 <= '0;
			strobe <= 1'b0;
			out_v_s1 <= 1'b0;
			for (int i = 0; i < 16; i++) begin
				level_q[i] <= LVL_RESET;
				fade_q[i] <= FADE_NORMAL;
				ramp_q[i] <= 1'b0;
				goal_q[i] <= '0;
				inc_q[i] <= '0;
				hue_q[i] <= '0;
			end
		end else begin
			strobe <= out_v_s1;
			out_v_s1 <= (state_q == ST_MULT);
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						unique case (cmd.kind)
							CMD_TICK: begin
								idx_q <= 4'd0;
								state_q <= ST_TICK;
							end
							CMD_SYNTH: begin
								hue_q[cmd.led] <= cmd.hue;
								fade_q[cmd.led] <= cmd.fade;
								ramp_q[cmd.led] <= cmd.slide;
								if (cmd.slide) begin
									goal_q[cmd.led] <= goal;
									inc_q[cmd.led] <= {2'b00, gq[31:18]};
								end else begin
									level_q[cmd.led] <= goal;
								end
								if (cmd.accent) begin
									idx_q <= cmd.arc_first;
									skip_q <= cmd.led;
									last_led_q <= cmd.arc_last;
									state_q <= ST_BOOST;
								end
							end
							CMD_DRUM: begin
								level_q[cmd.led] <= LVL_ONE;
								ramp_q[cmd.led] <= 1'b0;
								hue_q[cmd.led] <= cmd.hue;
								fade_q[cmd.led] <= cmd.fade;
							end
							default: begin
								ramp_q[cmd.led] <= 1'b0;
								fade_q[cmd.led] <= FADE_NORMAL;
							end
						endcase
					end
				end
				ST_BOOST: begin
					// boost uses level as already updated by the note itself
					if (idx_q != skip_q) begin
						goal_q[idx_q] <= bgoal;
						ramp_q[idx_q] <= 1'b1;
					end
					idx_q <= idx_q + 4'd1;
					if (idx_q == last_led_q) state_q <= ST_IDLE;
				end
				ST_TICK: begin
					// ramp leds finish here, fading leds go through the multiplier
					idx_s1 <= idx_q;
					hue_s1 <= hue_q[idx_q];
					if (ramp_q[idx_q]) begin
						if (level_q[idx_q] == goal_q[idx_q]) ramp_q[idx_q] <= 1'b0;
						prod_s1 <= {nlv, 16'd0};
					end else begin
						prod_s1 <= level_q[idx_q] * fade_q[idx_q];
					end
					state_q <= ST_MULT;
				end
				default: begin
					level_q[idx_s1] <= fl;
					lv_s1 <= fl;
					idx_q <= idx_q + 4'd1;
					state_q <= (idx_q == 4'd15) ? ST_IDLE : ST_TICK;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_v_s1) begin
			led_index <= idx_s1;
			red   <= 8'((32'(hue_s1[23:16]) * 32'(bb)) >> 15);
			green <= 8'((32'(hue_s1[15:8]) * 32'(bb)) >> 15);
			blue  <= 8'((32'(hue_s1[7:0]) * 32'(bb)) >> 15);
			last  <= (idx_s1 == 4'd15);
		end
	end
endmodule
`default_nettype wire

// ----- rtl/core/lrf_checker.sv -----
// ----------------------------------------------------------------------------
// lrf_checker: port-level checks of the fade engine
// Watches result beats over time.
// ----------------------------------------------------------------------------
`default_nettype none
module lrf_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       strobe,
	input wire logic [3:0] led_index,
	input wire logic       last
);
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (last == (led_index == 4'd15))) else $error("last flag");
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> ##2 (strobe && led_index == $past(led_index, 2) + 4'd1))
		else $error("led order");
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe) else $error("beat spacing");
endmodule
bind led_ring_fade_visualizer_top lrf_checker u_chk (
	.clk, .arst_n, .strobe, .led_index, .last
);
`default_nettype wire
